FILE: src/thavg_pkg.sv
// Shared types, constants and the thermistor curve for the thermistor average lookup.
// Used by every module of the block; it depends on nothing else.
package thavg_pkg;

  localparam int unsigned SAMPLE_W       = 12;
  localparam int unsigned DEG_W          = 8;
  localparam int unsigned CURVE_W        = 13;
  localparam int unsigned STORED_ENTRIES = 235;
  localparam int unsigned IDX_W          = 8;
  localparam int unsigned MAX_HIST       = 16;
  localparam int unsigned IN_CHAN        = 2;
  localparam int unsigned ZERO_OFFSET    = 121;

  localparam int unsigned HISTORY_DEPTH_DEF = 8;
  localparam int unsigned TABLE_ENTRIES_DEF = 235;
  localparam int unsigned CHANNELS_DEF      = 2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_ch0;
    logic [SAMPLE_W-1:0] sample_ch1;
  } in_data_t;

  typedef struct packed {
    logic signed [DEG_W-1:0] degrees_ch0;
    logic signed [DEG_W-1:0] degrees_ch1;
  } out_data_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_PUB
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic done;
  } status_t;

  // Converter reading for each table index, falling from full scale to zero.
  localparam logic [CURVE_W-1:0] NTC_CURVE [STORED_ENTRIES] = '{
    13'd4096, 13'd4077, 13'd4059, 13'd4041, 13'd4022, 13'd4004, 13'd3986, 13'd3967,
    13'd3949, 13'd3931, 13'd3912, 13'd3894, 13'd3876, 13'd3858, 13'd3840, 13'd3821,
    13'd3803, 13'd3785, 13'd3767, 13'd3749, 13'd3730, 13'd3712, 13'd3694, 13'd3675,
    13'd3658, 13'd3639, 13'd3621, 13'd3603, 13'd3585, 13'd3567, 13'd3548, 13'd3531,
    13'd3513, 13'd3494, 13'd3476, 13'd3458, 13'd3440, 13'd3422, 13'd3404, 13'd3386,
    13'd3368, 13'd3350, 13'd3332, 13'd3314, 13'd3296, 13'd3278, 13'd3260, 13'd3242,
    13'd3224, 13'd3206, 13'd3188, 13'd3170, 13'd3152, 13'd3134, 13'd3116, 13'd3099,
    13'd3081, 13'd3063, 13'd3045, 13'd3027, 13'd3009, 13'd2991, 13'd2973, 13'd2955,
    13'd2937, 13'd2920, 13'd2902, 13'd2884, 13'd2866, 13'd2848, 13'd2830, 13'd2812,
    13'd2795, 13'd2777, 13'd2759, 13'd2741, 13'd2724, 13'd2706, 13'd2688, 13'd2670,
    13'd2653, 13'd2635, 13'd2617, 13'd2599, 13'd2581, 13'd2564, 13'd2546, 13'd2528,
    13'd2510, 13'd2493, 13'd2475, 13'd2457, 13'd2440, 13'd2422, 13'd2405, 13'd2387,
    13'd2369, 13'd2351, 13'd2334, 13'd2316, 13'd2298, 13'd2281, 13'd2263, 13'd2245,
    13'd2228, 13'd2210, 13'd2193, 13'd2175, 13'd2157, 13'd2140, 13'd2122, 13'd2104,
    13'd2087, 13'd2069, 13'd2052, 13'd2034, 13'd2017, 13'd1999, 13'd1982, 13'd1964,
    13'd1947, 13'd1929, 13'd1929, 13'd1912, 13'd1894, 13'd1877, 13'd1859, 13'd1842,
    13'd1824, 13'd1807, 13'd1789, 13'd1772, 13'd1754, 13'd1737, 13'd1719, 13'd1702,
    13'd1684, 13'd1667, 13'd1649, 13'd1632, 13'd1614, 13'd1597, 13'd1580, 13'd1562,
    13'd1545, 13'd1527, 13'd1510, 13'd1493, 13'd1475, 13'd1458, 13'd1440, 13'd1423,
    13'd1405, 13'd1388, 13'd1371, 13'd1353, 13'd1336, 13'd1318, 13'd1301, 13'd1284,
    13'd1266, 13'd1249, 13'd1232, 13'd1214, 13'd1197, 13'd1180, 13'd1163, 13'd1145,
    13'd1128, 13'd1111, 13'd1093, 13'd1076, 13'd1059, 13'd1042, 13'd1024, 13'd1007,
    13'd990,  13'd973,  13'd955,  13'd938,  13'd921,  13'd903,  13'd886,  13'd869,
    13'd852,  13'd835,  13'd817,  13'd800,  13'd783,  13'd766,  13'd749,  13'd732,
    13'd714,  13'd697,  13'd680,  13'd663,  13'd646,  13'd629,  13'd611,  13'd594,
    13'd577,  13'd560,  13'd543,  13'd526,  13'd509,  13'd492,  13'd475,  13'd458,
    13'd441,  13'd423,  13'd406,  13'd389,  13'd372,  13'd355,  13'd338,  13'd321,
    13'd304,  13'd287,  13'd270,  13'd253,  13'd236,  13'd218,  13'd201,  13'd185,
    13'd168,  13'd151,  13'd134,  13'd117,  13'd100,  13'd83,   13'd65,   13'd49,
    13'd32,   13'd15,   13'd0
  };

endpackage

FILE: src/thavg_ctrl.sv
// Sequencer for the thermistor average lookup: accepts an item, runs the table walk
// and hands the result to the output register. Depends on thavg_pkg.
module thavg_ctrl import thavg_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_WALK;
        end
      end
      ST_WALK: begin
        if (status_i.done) begin
          state_d = ST_PUB;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_PUB: begin
        // The result moves on only once the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_pub_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> (!out_valid_q || out_ready_i))
    else $error("result written over a waiting result");

  a_load_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_WALK))
    else $error("accepted item did not start a walk");

  a_pub_shows_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |=> out_valid_o)
    else $error("published result not presented");

endmodule

FILE: src/thavg_dp.sv
// Datapath of the thermistor average lookup: per-channel history and running sum,
// table walk counter, per-channel match capture and the output register. Depends on thavg_pkg.
module thavg_dp import thavg_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int unsigned CHANNELS      = CHANNELS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  output status_t   status_o,
  input  in_data_t  in_data_i,
  output out_data_t out_data_o
);

  localparam int unsigned HistD = (HISTORY_DEPTH < 1) ? 1 :
                                  (HISTORY_DEPTH > MAX_HIST) ? MAX_HIST : HISTORY_DEPTH;
  localparam int unsigned Bound = (TABLE_ENTRIES < 1) ? 1 :
                                  (TABLE_ENTRIES > STORED_ENTRIES) ? STORED_ENTRIES :
                                  TABLE_ENTRIES;
  localparam int unsigned Lanes = (CHANNELS > IN_CHAN) ? IN_CHAN : CHANNELS;
  localparam int unsigned SumW  = $clog2(HistD * 4096);
  localparam int unsigned SumXW = SumW + 1;
  // Wide enough for the full-scale curve entry times the history depth.
  localparam int unsigned CmpW  = $clog2(HistD * 4096 + 1);

  logic [IDX_W-1:0]    k_q;
  logic                last;
  logic [CmpW-1:0]     thresh;
  logic [SAMPLE_W-1:0] sample [IN_CHAN];
  logic [IN_CHAN-1:0]  found;
  logic [DEG_W-1:0]    deg [IN_CHAN];
  out_data_t           out_q;

  assign sample[0] = in_data_i.sample_ch0;
  assign sample[1] = in_data_i.sample_ch1;

  assign last = (k_q == IDX_W'(Bound - 1));

  // floor(sum / depth) >= entry is the same test as sum >= entry * depth.
  assign thresh = CmpW'(NTC_CURVE[k_q]) * CmpW'(HistD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.load) begin
      k_q <= '0;
    end else if (cmd_i.step) begin
      k_q <= k_q + IDX_W'(1);
    end
  end

  for (genvar l = 0; l < IN_CHAN; l++) begin : g_lane
    if (l < Lanes) begin : g_on
      logic [SAMPLE_W-1:0] hist_q [HistD];
      logic [SumW-1:0]     sum_q;
      logic [SumW-1:0]     sum_d;
      logic                found_q;
      logic [IDX_W-1:0]    idx_q;
      logic                hit;

      // The running sum drops the oldest sample as the new one comes in.
      assign sum_d = SumW'(SumXW'(sum_q) + SumXW'(sample[l]) - SumXW'(hist_q[HistD-1]));
      assign hit   = (CmpW'(sum_q) >= thresh);

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          for (int i = 0; i < HistD; i++) begin
            hist_q[i] <= '0;
          end
          sum_q   <= '0;
          found_q <= 1'b0;
        end else if (cmd_i.load) begin
          for (int i = HistD - 1; i > 0; i--) begin
            hist_q[i] <= hist_q[i-1];
          end
          hist_q[0] <= sample[l];
          sum_q     <= sum_d;
          found_q   <= 1'b0;
        end else if (cmd_i.step && !found_q && (hit || last)) begin
          found_q <= 1'b1;
        end
      end

      // Without a match the walk saturates at the last usable entry.
      always_ff @(posedge clk_i) begin
        if (cmd_i.step && !found_q && (hit || last)) begin
          idx_q <= k_q;
        end
      end

      assign found[l] = found_q;
      assign deg[l]   = idx_q - DEG_W'(ZERO_OFFSET);
    end else begin : g_off
      assign found[l] = 1'b1;
      assign deg[l]   = '0;
    end
  end

  assign status_o.done = &found;

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_q.degrees_ch0 <= deg[0];
      out_q.degrees_ch1 <= deg[1];
    end
  end

  assign out_data_o = out_q;

  a_walk_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (k_q <= IDX_W'(Bound - 1)))
    else $error("table walk ran past the last entry");

  a_load_not_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.load && cmd_i.step))
    else $error("load and step issued together");

  a_publish_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |-> status_o.done)
    else $error("result published before every channel matched");

endmodule

FILE: src/thermistor_avg_table_lookup_top.sv
// Top level of the two-channel thermistor moving-average table lookup.
// Instantiates thavg_ctrl and thavg_dp; depends on thavg_pkg.
//
// Input channel: in_valid_i / in_ready_o with in_data_i carrying one 12-bit sample
// per thermistor channel. Output channel: out_valid_o / out_ready_i with out_data_o
// carrying one signed temperature in degrees per channel.
// Each channel keeps the last HISTORY_DEPTH samples (1 to 16) and a running sum of
// them. The floored mean is matched against the descending curve by a walk that tests
// one entry per cycle for both channels at once; the walk ends when every channel has
// matched, or at the last usable entry.
// How long one item occupies the block grows with the larger of the two matched
// indexes. in_ready_o is high only while no item is at work, so a new item is taken
// only once the last one has been published.
// A finished result sits in an output register; the next item is accepted while it
// waits. If the receiver still holds off when the following result is ready, the
// block waits in its publish state until the output register frees.
// Reset clears the histories and sums to zero and drops any pending result.
module thermistor_avg_table_lookup_top import thavg_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int unsigned CHANNELS      = CHANNELS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_data_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_data_t out_data_o
);

  cmd_t    cmd;
  status_t status;

  thavg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  thavg_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .CHANNELS      (CHANNELS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule
